/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion wrappers, clocked on clk, quiet during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/clsu_pkg.sv */
// ---------------------------------------------------------------------------
// clsu_pkg
// shared constants and codes of the cursor list store
// ---------------------------------------------------------------------------
package clsu_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_FIRST   = 3'd4,
    OP_LAST    = 3'd5,
    OP_NEXT    = 3'd6,
    OP_PRIOR   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BOUNDARY = 2'd3
  } status_t;

  // register word index, taken from paddr above the byte lanes
  localparam logic REG_CAPACITY = 1'b0;

endpackage

/* design/cursor_list_store_unit.sv */
// ---------------------------------------------------------------------------
// cursor_list_store_unit
// bounded ordered list with a cursor, command port plus apb register port
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; operation
// selects insert, remove, replace, clear, first, last, next or prior, and
// data_item carries the value for insert and replace.
// Exactly one result transaction follows each command: done is high for one
// cycle with status, cursor_item, cursor_position, item_count, list_empty and
// list_full valid in that same cycle. The receiver cannot stall, so the
// result is always taken in that cycle.
// Most commands go from the accepting edge straight to the result fetch. A
// replace or an insert into an empty list first writes the entry, a remove
// of the tail entry first updates count and cursor. Other removes first
// shift the entries behind the cursor down, an insert into a non-empty list
// those from the cursor on up, one entry per cycle through the one read and
// one write port of the entry memory. busy stays high until done has been
// shown, so the next command enters at the earliest on the cycle after done.
// The capacity_limit register sits at byte address 0; write it only while no
// command is in flight. Reset empties the list, sets the cursor to 0 and the
// limit to DEPTH; the entry memory needs no clearing.
// ---------------------------------------------------------------------------
module cursor_list_store_unit #(
  parameter int DEPTH      = clsu_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = clsu_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      operation,
  input  logic [DATA_WIDTH-1:0]           data_item,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [DATA_WIDTH-1:0]           cursor_item,
  output logic [IDX_W-1:0]                cursor_position,
  output logic [CNT_W-1:0]                item_count,
  output logic                            list_empty,
  output logic                            list_full,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clsu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [clsu_pkg::APB_DATA_W-1:0] pwdata,
  output logic [clsu_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import clsu_pkg::*;

  logic [CNT_W-1:0] capacity_limit;
  logic [CNT_W-1:0] limit;
  logic             cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[APB_ADDR_W-1] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CNT_W'(DEPTH);
    end else if (psel && penable && pwrite && cap_sel) begin
      capacity_limit <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = cap_sel ? {{(APB_DATA_W-CNT_W){1'b0}}, capacity_limit} : '0;

  // zero acts as one, anything above the depth acts as the depth
  always_comb begin
    limit = capacity_limit;
    if (capacity_limit == '0) begin
      limit = CNT_W'(1);
    end else if (capacity_limit > CNT_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end
  end

  clsu_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .operation       (operation),
    .data_item       (data_item),
    .limit           (limit),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .cursor_item     (cursor_item),
    .cursor_position (cursor_position),
    .item_count      (item_count),
    .list_empty      (list_empty),
    .list_full       (list_full)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `ASSERT_NEXT(a_done_single, done, !done && !busy)
  `ASSERT_SAME(a_count_bound, done, item_count <= CNT_W'(DEPTH))
  `ASSERT_SAME(a_cursor_in_list, done && !list_empty, CNT_W'(cursor_position) < item_count)
  `ASSERT_SAME(a_empty_zero, done && list_empty, cursor_position == '0 && cursor_item == '0)

endmodule

/* design/clsu_mem.sv */
// ---------------------------------------------------------------------------
// clsu_mem
// entry storage: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module clsu_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/clsu_step.sv */
// ---------------------------------------------------------------------------
// clsu_step
// shared index unit: one step up or down and a compare against a bound
// ---------------------------------------------------------------------------
module clsu_step #(
  parameter int IDX_W = 4
) (
  input  logic [IDX_W-1:0] idx,
  input  logic [IDX_W-1:0] bound,
  input  logic             up,
  output logic [IDX_W-1:0] sum,
  output logic             hit
);

  assign sum = up ? idx + IDX_W'(1) : idx - IDX_W'(1);
  assign hit = (idx == bound);

endmodule

/* design/clsu_ctrl.sv */
// ---------------------------------------------------------------------------
// clsu_ctrl
// operation sequencer: decodes a command, walks the shift, fetches the result
// ---------------------------------------------------------------------------
module clsu_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            operation,
  input  logic [DATA_WIDTH-1:0] data_item,
  input  logic [CNT_W-1:0]      limit,
  output logic                  busy,
  output logic                  done,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] cursor_item,
  output logic [IDX_W-1:0]      cursor_position,
  output logic [CNT_W-1:0]      item_count,
  output logic                  list_empty,
  output logic                  list_full
);

  import clsu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SH_UP, S_SH_DN, S_DRAIN, S_PUT, S_FIX, S_FETCH, S_RESP
  } state_t;

  state_t                state;
  op_t                   op_in;
  op_t                   op_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      cursor;
  logic [IDX_W-1:0]      src;
  logic [IDX_W-1:0]      dcur;
  logic [IDX_W-1:0]      wptr;
  logic                  wr_pend;
  status_t               status_q;
  logic                  empty_q;

  logic [CNT_W-1:0]      count_dec;
  logic [IDX_W-1:0]      last_idx;
  logic                  is_empty;
  logic                  is_full;

  logic [IDX_W-1:0]      st_idx;
  logic [IDX_W-1:0]      st_bound;
  logic                  st_up;
  logic [IDX_W-1:0]      st_sum;
  logic                  st_hit;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign op_in     = op_t'(operation);
  assign count_dec = count - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign is_empty  = (count == '0);
  assign is_full   = (count >= limit);

  // the step unit follows the cursor while deciding, the shift pointer otherwise
  always_comb begin
    st_idx   = src;
    st_up    = (state == S_SH_DN);
    st_bound = last_idx;
    if (state == S_IDLE || state == S_FIX) begin
      st_idx = cursor;
      st_up  = (op_in == OP_NEXT) || (op_in == OP_REMOVE);
    end
    if (state == S_SH_UP) begin
      st_bound = cursor;
    end
  end

  clsu_step #(
    .IDX_W (IDX_W)
  ) u_step (
    .idx   (st_idx),
    .bound (st_bound),
    .up    (st_up),
    .sum   (st_sum),
    .hit   (st_hit)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = src;
    unique case (state)
      S_SH_UP, S_SH_DN: begin
        mem_re = 1'b1;
        mem_we = wr_pend;
      end
      S_DRAIN: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor;
        mem_wdata = data_q;
      end
      S_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = cursor;
      end
      S_IDLE, S_FIX, S_RESP: begin
      end
    endcase
  end

  clsu_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      cursor          <= '0;
      wr_pend         <= 1'b0;
      done            <= 1'b0;
      status_q        <= ST_OK;
      op_q            <= OP_INSERT;
      empty_q         <= 1'b1;
      cursor_position <= '0;
      item_count      <= '0;
      list_full       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= op_in;
            data_q   <= data_item;
            wr_pend  <= 1'b0;
            status_q <= ST_OK;
            state    <= S_FETCH;
            unique case (op_in)
              OP_INSERT: begin
                if (is_full) begin
                  status_q <= ST_FULL;
                end else if (is_empty) begin
                  cursor <= '0;
                  state  <= S_PUT;
                end else begin
                  src   <= last_idx;
                  dcur  <= count[IDX_W-1:0];
                  state <= S_SH_UP;
                end
              end
              OP_REMOVE: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else if (st_hit) begin
                  state <= S_FIX;
                end else begin
                  src   <= st_sum;
                  dcur  <= cursor;
                  state <= S_SH_DN;
                end
              end
              OP_REPLACE: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  state <= S_PUT;
                end
              end
              OP_CLEAR: begin
                count  <= '0;
                cursor <= '0;
              end
              OP_FIRST: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  cursor <= '0;
                end
              end
              OP_LAST: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  cursor <= last_idx;
                end
              end
              OP_NEXT: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else if (st_hit) begin
                  status_q <= ST_BOUNDARY;
                end else begin
                  cursor <= st_sum;
                end
              end
              OP_PRIOR: begin
                if (is_empty) begin
                  status_q <= ST_EMPTY;
                end else if (cursor == '0) begin
                  status_q <= ST_BOUNDARY;
                end else begin
                  cursor <= st_sum;
                end
              end
            endcase
          end
        end
        // read one entry per cycle, write it one slot over in the next cycle
        S_SH_UP, S_SH_DN: begin
          wr_pend <= 1'b1;
          wptr    <= dcur;
          dcur    <= src;
          src     <= st_sum;
          if (st_hit) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          wr_pend <= 1'b0;
          state   <= (op_q == OP_INSERT) ? S_PUT : S_FIX;
        end
        S_PUT: begin
          if (op_q == OP_INSERT) begin
            count <= count + CNT_W'(1);
          end
          state <= S_FETCH;
        end
        // removing the tail entry sends the cursor back to the head
        S_FIX: begin
          count <= count_dec;
          if (st_hit) begin
            cursor <= '0;
          end
          state <= S_FETCH;
        end
        S_FETCH: begin
          empty_q         <= is_empty;
          cursor_position <= is_empty ? '0 : cursor;
          item_count      <= count;
          list_full       <= is_full;
          done            <= 1'b1;
          state           <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign status      = status_q;
  assign list_empty  = empty_q;
  assign cursor_item = empty_q ? '0 : mem_rdata;

endmodule

/* tb/cursor_list_store_unit_test.sv */
// ---------------------------------------------------------------------------
// cursor_list_store_unit_test
// self-checking bench for the cursor list store: commands are sent over the
// start/busy port with random idle bursts, the capacity register is rewritten
// over apb between phases, and every done strobe is compared field by field
// with a local model of the list, cursor and limit
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cursor_list_store_unit_test;
  import clsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned PHASE_COUNT   = 10;
  localparam int unsigned REPORT_LINES  = 40;

  typedef struct {
    status_t     status;
    logic [31:0] item;
    logic [3:0]  position;
    logic [4:0]  count;
    logic        empty;
    logic        full;
  } list_result_t;

  class list_tracker;
    logic [31:0]  entries [DEPTH_DEF];
    int unsigned  count;
    int unsigned  cursor;
    logic [4:0]   capacity;
    list_result_t expected_q [$];
    int unsigned  mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      count = 0;
      cursor = 0;
      capacity = 5'd16;
      mismatches = 0;
    endfunction

    // a limit of 0 behaves as 1, anything above the depth as the depth
    function int unsigned effective_limit();
      int unsigned lim;
      lim = 32'(capacity);
      if (lim < 1) lim = 1;
      if (lim > DEPTH_DEF) lim = DEPTH_DEF;
      return lim;
    endfunction

    function void set_capacity(logic [4:0] value);
      capacity = value;
    endfunction

    function void note_command(op_t op, logic [31:0] value);
      list_result_t r;
      status_t      st;
      int unsigned  i;
      st = ST_OK;
      case (op)
        OP_INSERT: begin
          if (count >= effective_limit()) begin
            st = ST_FULL;
          end else begin
            if (count == 0) cursor = 0;
            else for (i = count; i > cursor; i--) entries[i] = entries[i - 1];
            entries[cursor] = value;
            count++;
          end
        end
        OP_REMOVE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            for (i = cursor; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            if (cursor >= count) cursor = 0;
          end
        end
        OP_REPLACE: begin
          if (count == 0) st = ST_EMPTY;
          else entries[cursor] = value;
        end
        OP_CLEAR: begin
          count = 0;
          cursor = 0;
        end
        OP_FIRST: begin
          if (count == 0) st = ST_EMPTY;
          else cursor = 0;
        end
        OP_LAST: begin
          if (count == 0) st = ST_EMPTY;
          else cursor = count - 1;
        end
        OP_NEXT: begin
          if (count == 0) st = ST_EMPTY;
          else if (cursor + 1 < count) cursor++;
          else st = ST_BOUNDARY;
        end
        default: begin
          if (count == 0) st = ST_EMPTY;
          else if (cursor > 0) cursor--;
          else st = ST_BOUNDARY;
        end
      endcase
      r.status = st;
      if (count == 0) begin
        r.item = '0;
        r.position = '0;
      end else begin
        r.item = entries[cursor];
        r.position = cursor[3:0];
      end
      r.count = count[4:0];
      r.empty = (count == 0);
      r.full = (count >= effective_limit());
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < REPORT_LINES) $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] item, logic [3:0] pos,
                      logic [4:0] cnt, logic empty, logic full);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no command pending (status %0d count %0d)", st, cnt));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status: expected %s got %0d", e.status.name(), st));
      if (item !== e.item)
        report($sformatf("cursor_item: expected %08h got %08h", e.item, item));
      if (pos !== e.position)
        report($sformatf("cursor_position: expected %0d got %0d", e.position, pos));
      if (cnt !== e.count)
        report($sformatf("item_count: expected %0d got %0d", e.count, cnt));
      if (empty !== e.empty)
        report($sformatf("list_empty: expected %0b got %0b", e.empty, empty));
      if (full !== e.full)
        report($sformatf("list_full: expected %0b got %0b", e.full, full));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  operation = OP_CLEAR;
  logic [31:0] data_item = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] cursor_item;
  logic [3:0]  cursor_position;
  logic [4:0]  item_count;
  logic        list_empty;
  logic        list_full;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  list_tracker tracker = new();
  int unsigned cycles = 0;

  cursor_list_store_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .data_item(data_item),
    .done(done), .status(status), .cursor_item(cursor_item),
    .cursor_position(cursor_position), .item_count(item_count),
    .list_empty(list_empty), .list_full(list_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      tracker.check_result(status, cursor_item, cursor_position, item_count,
                           list_empty, list_full);
  end

  function automatic op_t pick_op(int unsigned insert_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < insert_weight) return OP_INSERT;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_REMOVE;
    if (r < 37) return OP_REPLACE;
    if (r < 40) return OP_CLEAR;
    if (r < 52) return OP_FIRST;
    if (r < 64) return OP_LAST;
    if (r < 82) return OP_NEXT;
    return OP_PRIOR;
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // start stays high between back-to-back transactions
  task automatic issue(op_t op, logic [31:0] value, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    data_item <= value;
    do @(posedge clk); while (busy);
    tracker.note_command(op, value);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[4:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_capacity(value);
  endtask

  initial begin
    logic [4:0]  setting;
    int unsigned insert_weight;
    bit          idle_on;
    int unsigned gap;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list errors on every op that needs an entry
    issue(OP_REMOVE, 32'h1234_5678, 0);
    issue(OP_REPLACE, 32'hFFFF_FFFF, 0);
    issue(OP_FIRST, 32'h0, 0);
    issue(OP_LAST, 32'h0, 0);
    issue(OP_NEXT, 32'h0, 0);
    issue(OP_PRIOR, 32'h0, 0);
    issue(OP_INSERT, 32'h0000_0000, 0);
    issue(OP_INSERT, 32'hFFFF_FFFF, 0);
    issue(OP_INSERT, 32'h8000_0001, 0);
    issue(OP_LAST, 32'h0, 0);
    issue(OP_NEXT, 32'h0, 0);
    issue(OP_PRIOR, 32'h0, 0);
    issue(OP_FIRST, 32'h0, 0);
    issue(OP_PRIOR, 32'h0, 0);
    issue(OP_NEXT, 32'h0, 0);
    issue(OP_REPLACE, 32'h5555_5555, 0);
    issue(OP_LAST, 32'h0, 0);
    // removing the tail entry wraps the cursor to the head
    issue(OP_REMOVE, 32'h0, 0);
    issue(OP_REMOVE, 32'h0, 0);
    issue(OP_CLEAR, 32'h0, 0);
    issue(OP_INSERT, 32'hAAAA_AAAA, 0);
    issue(OP_INSERT, 32'h0000_0001, 0);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: setting = 5'd16;
        1: setting = 5'd0;
        2: setting = 5'd31;
        3: setting = 5'd1;
        4: setting = 5'd17;
        5: setting = 5'd8;
        6: setting = 5'd2;
        7: setting = 5'd15;
        default: setting = 5'($urandom_range(0, 31));
      endcase
      write_capacity(setting);
      @(posedge clk);
      // alternate filling and draining so the limit gets hit and overrun
      insert_weight = (p % 2 == 0) ? 60 : 25;
      idle_on = (p < PHASE_COUNT - 2) && (p % 3 != 2);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        issue(pick_op(insert_weight), pick_data(), gap);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
